// ===== rtl/swts_pkg.sv =====
// Package for the sliding-window timing statistics block.
// Holds field widths, opcodes and the item and request structs.
// Used by every module of the block; depends on nothing.
package swts_pkg;

    localparam int VALUE_BITS = 24;
    localparam int FRAME_BITS = 32;
    localparam int COUNT_BITS = 9;
    localparam int SUM_BITS   = 32;
    localparam int SQ_BITS    = 56;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [FRAME_BITS-1:0] frame_number;
        logic [VALUE_BITS-1:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] sample_count;
        logic [SUM_BITS-1:0]   window_sum;
        logic [SQ_BITS-1:0]    window_sum_sq;
        logic [VALUE_BITS-1:0] min_seen;
        logic [VALUE_BITS-1:0] max_seen;
        logic [FRAME_BITS-1:0] latest_frame;
    } out_item_t;

    // Work handed from the front stage to the sum accumulator.
    typedef struct packed {
        logic                    clear;
        logic                    evict;
        logic [VALUE_BITS-1:0]   value;
        logic [VALUE_BITS-1:0]   old_value;
        logic [2*VALUE_BITS-1:0] value_sq;
        logic [2*VALUE_BITS-1:0] old_sq;
    } acc_req_t;

endpackage

// ===== rtl/swts_cell.sv =====
// One cell of the sample chain: holds one sample and passes it on.
// Depends on swts_pkg for the sample width.
module swts_cell (
    input  logic                           clk,
    input  logic                           shift_en,
    input  logic [swts_pkg::VALUE_BITS-1:0] d,
    output logic [swts_pkg::VALUE_BITS-1:0] q
);

    logic [swts_pkg::VALUE_BITS-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= d;
        end
    end

    assign q = value_reg;

endmodule

// ===== rtl/swts_ring.sv =====
// Window storage as a chain of swts_cell instances; the last cell holds
// the oldest sample. Depends on swts_pkg and swts_cell.
module swts_ring #(
    parameter int DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           shift_en,
    input  logic [swts_pkg::VALUE_BITS-1:0] data_in,
    output logic [swts_pkg::VALUE_BITS-1:0] oldest
);

    logic [swts_pkg::VALUE_BITS-1:0] tap [DEPTH+1];

    assign tap[0] = data_in;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        swts_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .d        (tap[i]),
            .q        (tap[i+1])
        );
    end

    assign oldest = tap[DEPTH];

endmodule

// ===== rtl/swts_accum.sv =====
// Running sum and sum of squares over the window, one request per cycle while update is high.
// Depends on swts_pkg for widths and the request struct.
module swts_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        update,
    input  swts_pkg::acc_req_t          req,
    output logic [swts_pkg::SUM_BITS-1:0] sum,
    output logic [swts_pkg::SQ_BITS-1:0]  sum_sq
);

    localparam int SUM_BITS = swts_pkg::SUM_BITS;
    localparam int SQ_BITS  = swts_pkg::SQ_BITS;
    localparam int VB       = swts_pkg::VALUE_BITS;

    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic [SQ_BITS-1:0]  sum_sq_reg, sum_sq_next;
    logic [SUM_BITS-1:0] old_term;
    logic [SQ_BITS-1:0]  old_sq_term;

    always_comb
    begin
        old_term    = req.evict ? {{(SUM_BITS-VB){1'b0}}, req.old_value} : '0;
        old_sq_term = req.evict ? {{(SQ_BITS-2*VB){1'b0}}, req.old_sq} : '0;
        if (req.clear)
        begin
            sum_next    = '0;
            sum_sq_next = '0;
        end
        else
        begin
            sum_next    = sum_reg + {{(SUM_BITS-VB){1'b0}}, req.value} - old_term;
            sum_sq_next = sum_sq_reg + {{(SQ_BITS-2*VB){1'b0}}, req.value_sq}
                          - old_sq_term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            sum_sq_reg <= '0;
        end
        else if (update)
        begin
            sum_reg    <= sum_next;
            sum_sq_reg <= sum_sq_next;
        end
    end

    assign sum    = sum_reg;
    assign sum_sq = sum_sq_reg;

endmodule

// ===== rtl/sliding_window_timing_stats_top.sv =====
// Top level of the sliding-window timing statistics block.
// Depends on swts_pkg, swts_ring (chain of swts_cell) and swts_accum.
//
// Usage: items enter on the sample channel (sample_valid, sample_stall,
// sample) and each item yields exactly one result item on the stats channel
// (stats_valid, stats_stall, stats). An add item shifts its sample into a
// chain of WINDOW_DEPTH cells; once the window is full the sample falling
// off the end of the chain is subtracted from both running sums. A clear
// item restores every statistic to its reset value.
//
// Each accepted item is registered in the front stage and then in the
// accumulator stage, the output. Unless the receiver stalls, the block takes
// one item per cycle: the front stage squares the new and the evicted sample,
// and the accumulator stage folds them into the sums by add-and-subtract.
//
// Reset clears the fill count, sums, min, max and latest frame; the sample
// chain itself is not cleared, since a cell is only read after it has been
// written. When the receiver stalls a waiting result, the whole two-stage
// pipeline holds and sample_stall is raised in the same cycle.
module sliding_window_timing_stats_top #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  swts_pkg::in_item_t  sample,
    output logic                stats_valid,
    input  logic                stats_stall,
    output swts_pkg::out_item_t stats
);

    localparam int VB = swts_pkg::VALUE_BITS;
    localparam int FB = swts_pkg::FRAME_BITS;
    localparam int NB = swts_pkg::COUNT_BITS;
    // Fill count must be able to hold the depth itself.
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    // Pipeline advances whenever the output register is free or being taken.
    logic advance;
    logic accept;
    logic add_item;

    assign advance      = !(stats_valid && stats_stall);
    assign sample_stall = !advance;
    assign accept       = sample_valid && advance;
    assign add_item     = sample.opcode == swts_pkg::OP_ADD;

    // Front stage state: fill count and the unwindowed statistics.
    logic [CW-1:0] fill_reg, fill_next;
    logic [VB-1:0] min_reg, min_next;
    logic [VB-1:0] max_reg, max_next;
    logic [FB-1:0] frame_reg, frame_next;
    logic          evict;
    logic [VB-1:0] oldest;
    logic [CW+NB-1:0] fill_ext;

    swts_ring #(
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk      (clk),
        .shift_en (accept && add_item),
        .data_in  (sample.sample_value),
        .oldest   (oldest)
    );

    always_comb
    begin
        evict      = 1'b0;
        fill_next  = fill_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        frame_next = frame_reg;
        if (!add_item)
        begin
            fill_next  = '0;
            min_next   = '1;
            max_next   = '0;
            frame_next = '0;
        end
        else
        begin
            // The oldest sample leaves only once the window is full.
            evict      = fill_reg == CW'(WINDOW_DEPTH);
            fill_next  = evict ? fill_reg : fill_reg + 1'b1;
            frame_next = sample.frame_number;
            if (sample.sample_value < min_reg)
            begin
                min_next = sample.sample_value;
            end
            if (sample.sample_value > max_reg)
            begin
                max_next = sample.sample_value;
            end
        end
        fill_ext = {{NB{1'b0}}, fill_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            frame_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg  <= fill_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            frame_reg <= frame_next;
        end
    end

    // Front stage registers: squares and a snapshot of the statistics.
    logic               s1_valid_reg;
    swts_pkg::acc_req_t s1_req_reg;
    logic [NB-1:0]      s1_count_reg;
    logic [VB-1:0]      s1_min_reg;
    logic [VB-1:0]      s1_max_reg;
    logic [FB-1:0]      s1_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg.clear     <= !add_item;
            s1_req_reg.evict     <= evict;
            s1_req_reg.value     <= sample.sample_value;
            s1_req_reg.old_value <= oldest;
            s1_req_reg.value_sq  <= sample.sample_value * sample.sample_value;
            s1_req_reg.old_sq    <= oldest * oldest;
            s1_count_reg         <= fill_ext[NB-1:0];
            s1_min_reg           <= min_next;
            s1_max_reg           <= max_next;
            s1_frame_reg         <= frame_next;
        end
    end

    // Accumulator stage, which doubles as the output register.
    logic                       out_valid_reg;
    logic [NB-1:0]              out_count_reg;
    logic [VB-1:0]              out_min_reg;
    logic [VB-1:0]              out_max_reg;
    logic [FB-1:0]              out_frame_reg;
    logic [swts_pkg::SUM_BITS-1:0] win_sum;
    logic [swts_pkg::SQ_BITS-1:0]  win_sum_sq;

    swts_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance && s1_valid_reg),
        .req    (s1_req_reg),
        .sum    (win_sum),
        .sum_sq (win_sum_sq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_count_reg <= s1_count_reg;
            out_min_reg   <= s1_min_reg;
            out_max_reg   <= s1_max_reg;
            out_frame_reg <= s1_frame_reg;
        end
    end

    assign stats_valid         = out_valid_reg;
    assign stats.sample_count  = out_count_reg;
    assign stats.window_sum    = win_sum;
    assign stats.window_sum_sq = win_sum_sq;
    assign stats.min_seen      = out_min_reg;
    assign stats.max_seen      = out_max_reg;
    assign stats.latest_frame  = out_frame_reg;

    // The fill count never runs past the window depth.
    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW_DEPTH))
        else $error("fill count exceeds window depth");

    // A clear request never evicts a sample.
    a_clear_no_evict : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_req_reg.clear && s1_req_reg.evict))
        else $error("eviction requested by a clear item");

    // Min at all ones with max at zero means no sample since clear.
    a_empty_stats : assert property (@(posedge clk) disable iff (!rst_n)
        (stats_valid && stats.max_seen == '0 && stats.min_seen == '1)
        |-> (stats.window_sum == '0 && stats.window_sum_sq == '0
             && stats.sample_count == '0))
        else $error("empty statistics carry nonzero sums");

    // A front-stage item held by a stall keeps its request.
    a_hold_req : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_req_reg)))
        else $error("front stage changed while stalled");

endmodule

// ===== sim/sliding_window_timing_stats_top_tb.sv =====
// Self-checking testbench for the sliding-window timing statistics block.
// Depends on swts_pkg and sliding_window_timing_stats_top; it predicts every
// result item on its own and compares it field by field.
module sliding_window_timing_stats_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_DEPTH = 256;
    // This limit leaves a wide margin for the slowest correct run of roughly 2000 items.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;

    localparam int VALUE_BITS = swts_pkg::VALUE_BITS;
    localparam int FRAME_BITS = swts_pkg::FRAME_BITS;
    localparam int COUNT_BITS = swts_pkg::COUNT_BITS;
    localparam int SUM_BITS   = swts_pkg::SUM_BITS;
    localparam int SQ_BITS    = swts_pkg::SQ_BITS;

    logic                clk;
    logic                rst_n;
    logic                sample_valid;
    logic                sample_stall;
    swts_pkg::in_item_t  sample;
    logic                stats_valid;
    logic                stats_stall = 1'b0;
    swts_pkg::out_item_t stats;

    sliding_window_timing_stats_top #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample      (sample),
        .stats_valid (stats_valid),
        .stats_stall (stats_stall),
        .stats       (stats)
    );

    // Free-running clock with a 20 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the window statistics. It mirrors the block's state
    // and is advanced once for every item that the block accepts.
    // ------------------------------------------------------------------
    logic [VALUE_BITS-1:0] shadow_ring [WINDOW_DEPTH];
    int                    shadow_wr_ptr;
    int                    shadow_fill;
    logic [SUM_BITS-1:0]   shadow_sum;
    logic [SQ_BITS-1:0]    shadow_sum_sq;
    logic [VALUE_BITS-1:0] shadow_min;
    logic [VALUE_BITS-1:0] shadow_max;
    logic [FRAME_BITS-1:0] shadow_frame;

    // Stats that the block still owes, oldest first.
    swts_pkg::out_item_t expected_stats [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  sender_gaps_on   = 1'b1;
    bit  receiver_stalls_on = 1'b1;

    // A clear restores every statistic but leaves the ring contents alone;
    // the fill count guarantees that stale entries are never evicted.
    function automatic void clear_shadow_stats();
        shadow_wr_ptr = 0;
        shadow_fill   = 0;
        shadow_sum    = '0;
        shadow_sum_sq = '0;
        shadow_min    = '1;
        shadow_max    = '0;
        shadow_frame  = '0;
    endfunction

    // Applies one accepted item to the shadow state and returns the stats
    // the block must report for it.
    function automatic swts_pkg::out_item_t advance_window_stats(swts_pkg::in_item_t item);
        logic [SQ_BITS-1:0]    new_wide;
        logic [SQ_BITS-1:0]    old_wide;
        logic [VALUE_BITS-1:0] new_value;
        swts_pkg::out_item_t   result;

        if (item.opcode == swts_pkg::OP_CLEAR)
        begin
            clear_shadow_stats();
        end
        else
        begin
            new_value = item.sample_value;
            new_wide  = SQ_BITS'(new_value);
            // Once the window is full the slot about to be overwritten
            // holds the oldest sample, which drops out of both sums.
            if (shadow_fill >= WINDOW_DEPTH)
            begin
                old_wide      = SQ_BITS'(shadow_ring[shadow_wr_ptr]);
                shadow_sum    = shadow_sum - SUM_BITS'(old_wide);
                shadow_sum_sq = shadow_sum_sq - old_wide * old_wide;
                shadow_fill   = WINDOW_DEPTH - 1;
            end
            shadow_ring[shadow_wr_ptr] = new_value;
            shadow_wr_ptr = (shadow_wr_ptr + 1) % WINDOW_DEPTH;
            shadow_fill   = shadow_fill + 1;
            shadow_frame  = item.frame_number;
            shadow_sum    = shadow_sum + SUM_BITS'(new_wide);
            shadow_sum_sq = shadow_sum_sq + new_wide * new_wide;
            // Min and max cover everything since the last clear, not just
            // the window; equal values leave them as they are.
            if (new_value < shadow_min)
                shadow_min = new_value;
            if (new_value > shadow_max)
                shadow_max = new_value;
        end

        result.sample_count  = COUNT_BITS'(shadow_fill);
        result.window_sum    = shadow_sum;
        result.window_sum_sq = shadow_sum_sq;
        result.min_seen      = shadow_min;
        result.max_seen      = shadow_max;
        result.latest_frame  = shadow_frame;
        return result;
    endfunction

    function automatic swts_pkg::in_item_t add_item(logic [FRAME_BITS-1:0] frame,
                                                    logic [VALUE_BITS-1:0] value);
        swts_pkg::in_item_t item;

        item.opcode       = swts_pkg::OP_ADD;
        item.frame_number = frame;
        item.sample_value = value;
        return item;
    endfunction

    // A clear carries random payload, which the block must ignore.
    function automatic swts_pkg::in_item_t clear_item();
        swts_pkg::in_item_t item;

        item.opcode       = swts_pkg::OP_CLEAR;
        item.frame_number = $urandom;
        item.sample_value = VALUE_BITS'($urandom);
        return item;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_idle_length();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // Sends one item and waits until the block takes it. The expected stats
    // are queued at the edge of acceptance. Valid stays high between
    // back-to-back items, so it is never lowered and raised in one step.
    task automatic send_item(swts_pkg::in_item_t item);
        int idle;

        idle = sender_gaps_on ? pick_idle_length() : 0;
        if (idle > 0)
        begin
            sample_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= item;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        expected_stats.push_back(advance_window_stats(item));
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls the stats channel in random bursts. Runs of no
    // stall alternate with short and occasional long stalls.
    // ------------------------------------------------------------------
    int stall_hold = 0;

    always @(posedge clk)
    begin
        int roll;

        if (!receiver_stalls_on)
        begin
            stats_stall <= 1'b0;
            stall_hold  = 0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold = stall_hold - 1;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
            begin
                stats_stall <= 1'b0;
                stall_hold  = $urandom_range(0, 6);
            end
            else if (roll < 93)
            begin
                stats_stall <= 1'b1;
                stall_hold  = $urandom_range(0, 2);
            end
            else
            begin
                stats_stall <= 1'b1;
                stall_hold  = $urandom_range(8, 40);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted stats item is matched against the
    // oldest expectation, one field at a time.
    // ------------------------------------------------------------------
    task automatic compare_field(string field, longint unsigned want,
                                 longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        swts_pkg::out_item_t want;

        if (rst_n && stats_valid && !stats_stall)
        begin
            if (expected_stats.size() == 0)
            begin
                $error("stats item arrived with no item outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_stats.pop_front();
                compare_field("sample_count", want.sample_count, stats.sample_count);
                compare_field("window_sum", want.window_sum, stats.window_sum);
                compare_field("window_sum_sq", want.window_sum_sq, stats.window_sum_sq);
                compare_field("min_seen", want.min_seen, stats.min_seen);
                compare_field("max_seen", want.max_seen, stats.max_seen);
                compare_field("latest_frame", want.latest_frame, stats.latest_frame);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, equal values against min and max, clears with
    // arbitrary payload, back-to-back clears, and an all-ones sample right
    // after a clear (equal to the empty minimum).
    task automatic test_directed_corners();
        send_item(add_item(32'h0000_0000, 24'h00_0000));
        send_item(add_item(32'hFFFF_FFFF, 24'hFF_FFFF));
        send_item(add_item(32'h0000_0001, 24'h00_0000));
        send_item(add_item(32'h8000_0000, 24'hFF_FFFF));
        send_item(add_item(32'h5555_5555, 24'hAA_AAAA));
        send_item(add_item(32'hAAAA_AAAA, 24'h55_5555));
        send_item(clear_item());
        send_item(clear_item());
        send_item(add_item(32'h1234_5678, 24'hFF_FFFF));
        send_item(add_item(32'h1234_5679, 24'h00_0064));
        send_item(add_item(32'h1234_567A, 24'h00_0064));
        send_item(clear_item());
        send_item(add_item(32'h0000_00FF, 24'h00_0064));
        send_item(add_item(32'h0000_0100, 24'h00_0064));
        send_item(clear_item());
    endtask

    // Fills the window with full-scale samples and keeps going, so both
    // sums reach their largest values and then hold there through eviction.
    task automatic test_full_scale_window();
        send_item(clear_item());
        for (int i = 0; i < WINDOW_DEPTH + 40; i++)
            send_item(add_item($urandom, 24'hFF_FFFF));
    endtask

    // Long stream of adds in segments with different value shapes. Clears
    // are rare so the window fills and eviction runs most of the time.
    // Idling on each side is switched off now and then for a stretch.
    task automatic test_sliding_stream(int total);
        int                    shape;
        int                    segment_left;
        logic [VALUE_BITS-1:0] favorite;
        logic [VALUE_BITS-1:0] value;

        segment_left = 0;
        shape        = 0;
        favorite     = '0;
        for (int n = 0; n < total; n++)
        begin
            if (segment_left == 0)
            begin
                segment_left       = $urandom_range(40, 300);
                shape              = $urandom_range(0, 3);
                favorite           = VALUE_BITS'($urandom);
                sender_gaps_on     = ($urandom_range(0, 3) != 0);
                receiver_stalls_on = ($urandom_range(0, 3) != 0);
            end
            segment_left--;

            case (shape)
                0: value = VALUE_BITS'($urandom);
                1: value = VALUE_BITS'($urandom_range(0, 255));
                2: value = VALUE_BITS'($urandom_range(24'hFF_FF00, 24'hFF_FFFF));
                default: value = ($urandom_range(0, 3) == 0) ?
                                 VALUE_BITS'($urandom) : favorite;
            endcase

            if ($urandom_range(0, 399) == 0)
                send_item(clear_item());
            else
                send_item(add_item($urandom, value));
        end
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    // Frequent clears mixed with short runs of adds, so clears land at many
    // fill levels of a partly filled window.
    task automatic test_clear_storm(int total);
        for (int n = 0; n < total; n++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(clear_item());
            else
                send_item(add_item($urandom, VALUE_BITS'($urandom)));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, run the tests, then drain and report.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        clear_shadow_stats();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_full_scale_window();
        test_sliding_stream(1500);
        test_clear_storm(140);

        sample_valid <= 1'b0;
        // Every outstanding item must come back before the final check; the
        // watchdog catches the case where one never does.
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
